// ----- hdl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A condition that, once seen, must be followed by another in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/cicd_pkg.sv -----
// Package with the widths, constants and types of the CIC decimator.
package cicd_pkg;

  localparam int STAGES_DEFAULT = 4;
  localparam int ACC_W = 64;
  localparam int SAMPLE_W = 24;
  localparam int FACTOR_W = 7;
  localparam int GAIN_W = 33;
  localparam int PHASE_W = 6;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 33;

  localparam logic [FACTOR_W-1:0] FACTOR_MAX = 7'd64;
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 7'd1;
  localparam logic [GAIN_W-1:0] GAIN_ONE = {1'b1, 32'd0};

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FACTOR = 2'd0,
    CFG_GAIN   = 2'd1
  } cfg_index_t;

  typedef struct packed {
    logic             valid;
    logic [ACC_W-1:0] data;
  } cicd_push_t;

endpackage

// ----- hdl/cicd_queue.sv -----
// Small first-in first-out queue of words with a fill count.
module cicd_queue #(
  parameter int WIDTH = 64,
  parameter int AW = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic [AW:0]      count
);

  logic [WIDTH-1:0] mem [1 << AW];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count + (AW + 1)'(push) - (AW + 1)'(pop);
    end
  end

  assign rdata = mem[rd_ptr];

endmodule

// ----- hdl/cicd_front.sv -----
// Front end: phase counter, pipelined integrator chain and queue credits.
module cicd_front #(
  parameter int STAGES = cicd_pkg::STAGES_DEFAULT,
  parameter int QUEUE_AW = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [cicd_pkg::SAMPLE_W-1:0] sample_in,
  input  logic [cicd_pkg::FACTOR_W-1:0] factor,
  input  logic                          mid_pop,
  output logic                          full,
  output cicd_pkg::cicd_push_t          mid_push
);

  import cicd_pkg::*;

  localparam int QD = 1 << QUEUE_AW;

  logic [ACC_W-1:0] integ [STAGES];
  logic [ACC_W-1:0] tok_data [STAGES];
  logic [STAGES-1:0] tok_valid;
  logic [STAGES-1:0] tok_last;
  logic [ACC_W-1:0] in_d [STAGES];
  logic [ACC_W-1:0] sum [STAGES];
  logic [STAGES-1:0] in_v;
  logic [STAGES-1:0] in_l;
  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] phase_next;
  logic [FACTOR_W-1:0] f_eff;
  logic last;
  logic [QUEUE_AW:0] used;

  always_comb begin
    if (factor == '0) begin
      f_eff = FACTOR_RESET;
    end else if (factor > FACTOR_MAX) begin
      f_eff = FACTOR_MAX;
    end else begin
      f_eff = factor;
    end
    last = ({1'b0, phase} + FACTOR_W'(1)) >= f_eff;
    phase_next = last ? '0 : phase + PHASE_W'(1);
  end

  always_comb begin
    in_v[0] = accept;
    in_l[0] = last;
    in_d[0] = {{(ACC_W - SAMPLE_W){sample_in[SAMPLE_W-1]}}, sample_in};
    for (int i = 1; i < STAGES; i++) begin
      in_v[i] = tok_valid[i-1];
      in_l[i] = tok_last[i-1];
      in_d[i] = tok_data[i-1];
    end
    for (int i = 0; i < STAGES; i++) begin
      sum[i] = integ[i] + in_d[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STAGES; i++) begin
        integ[i] <= '0;
      end
      tok_valid <= '0;
      tok_last <= '0;
      phase <= '0;
      used <= '0;
    end else begin
      tok_valid <= in_v;
      tok_last <= in_l;
      for (int i = 0; i < STAGES; i++) begin
        if (in_v[i]) begin
          integ[i] <= sum[i];
        end
      end
      if (accept) begin
        phase <= phase_next;
      end
      used <= used + (QUEUE_AW + 1)'(accept && last) - (QUEUE_AW + 1)'(mid_pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < STAGES; i++) begin
      if (in_v[i]) begin
        tok_data[i] <= sum[i];
      end
    end
  end

  assign full = (used == (QUEUE_AW + 1)'(QD));
  assign mid_push.valid = tok_valid[STAGES-1] && tok_last[STAGES-1];
  assign mid_push.data = tok_data[STAGES-1];

endmodule

// ----- hdl/cicd_back.sv -----
// Back end: pipelined comb chain, gain multiply and saturation.
module cicd_back #(
  parameter int STAGES = cicd_pkg::STAGES_DEFAULT,
  parameter int QUEUE_AW = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          mid_empty,
  input  logic [cicd_pkg::ACC_W-1:0]    mid_data,
  output logic                          mid_pop,
  input  logic [cicd_pkg::GAIN_W-1:0]   gain,
  input  logic                          out_pop,
  output logic                          out_push,
  output logic [cicd_pkg::SAMPLE_W-1:0] out_data
);

  import cicd_pkg::*;

  localparam int QD = 1 << QUEUE_AW;
  localparam logic signed [65:0] A_HI = 66'sd1099511627776;
  localparam logic signed [65:0] A_LO = -66'sd1099511627776;
  localparam logic signed [41:0] SUM_MAX = 42'sd8388607;
  localparam logic signed [41:0] SUM_MIN = -42'sd8388608;

  logic [ACC_W-1:0] dly [STAGES];
  logic [ACC_W-1:0] tok_data [STAGES];
  logic [STAGES-1:0] tok_valid;
  logic [ACC_W-1:0] in_d [STAGES];
  logic [ACC_W-1:0] diff [STAGES];
  logic [STAGES-1:0] in_v;
  logic [GAIN_W-1:0] gc;
  logic signed [31:0] sh;
  logic [31:0] lo;
  logic [64:0] lo_prod;
  logic signed [65:0] a_reg;
  logic [32:0] b_reg;
  logic mult_valid;
  logic signed [41:0] total;
  logic [QUEUE_AW:0] used;

  assign mid_pop = !mid_empty && (used != (QUEUE_AW + 1)'(QD));
  assign gc = gain[GAIN_W-1] ? GAIN_ONE : gain;

  always_comb begin
    in_v[0] = mid_pop;
    in_d[0] = mid_data;
    for (int i = 1; i < STAGES; i++) begin
      in_v[i] = tok_valid[i-1];
      in_d[i] = tok_data[i-1];
    end
    for (int i = 0; i < STAGES; i++) begin
      diff[i] = in_d[i] - dly[i];
    end
    sh = signed'(tok_data[STAGES-1][63:32]);
    lo = tok_data[STAGES-1][31:0];
    lo_prod = 65'(lo) * 65'(gc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STAGES; i++) begin
        dly[i] <= '0;
      end
      tok_valid <= '0;
      mult_valid <= 1'b0;
      used <= '0;
    end else begin
      tok_valid <= in_v;
      mult_valid <= tok_valid[STAGES-1];
      for (int i = 0; i < STAGES; i++) begin
        if (in_v[i]) begin
          dly[i] <= in_d[i];
        end
      end
      used <= used + (QUEUE_AW + 1)'(mid_pop) - (QUEUE_AW + 1)'(out_pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < STAGES; i++) begin
      if (in_v[i]) begin
        tok_data[i] <= diff[i];
      end
    end
    if (tok_valid[STAGES-1]) begin
      a_reg <= 66'(sh) * signed'({1'b0, gc});
      b_reg <= lo_prod[64:32];
    end
  end

  always_comb begin
    total = signed'(a_reg[41:0]) + signed'({9'd0, b_reg});
    if (a_reg > A_HI) begin
      out_data = 24'h7FFFFF;
    end else if (a_reg < A_LO) begin
      out_data = 24'h800000;
    end else if (total > SUM_MAX) begin
      out_data = 24'h7FFFFF;
    end else if (total < SUM_MIN) begin
      out_data = 24'h800000;
    end else begin
      out_data = total[SAMPLE_W-1:0];
    end
  end

  assign out_push = mult_valid;

endmodule

// ----- hdl/cic_decimator_top.sv -----
// Top level of the CIC decimator: configuration, queues and both halves.
// A group-ending sample passes the integrator stages, mid queue, comb stages, multiply
// register and result queue. Throughput: one input sample per cycle while full is low,
// one result per decimation_factor samples, set by one 64-bit add per stage and cycle.
// Reset clears the integrators, comb delays, phase counter and queues at once and sets
// decimation_factor to 1 and gain_correction to 1.0; no clearing pass follows.
`include "assert_macros.svh"

module cic_decimator_top #(
  parameter int STAGES = cicd_pkg::STAGES_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic signed [cicd_pkg::SAMPLE_W-1:0] sample_in,
  output logic                             empty,
  input  logic                             pop,
  output logic signed [cicd_pkg::SAMPLE_W-1:0] sample_out,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cicd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cicd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import cicd_pkg::*;

  localparam int QUEUE_AW = $clog2(STAGES + 4);
  localparam int QD = 1 << QUEUE_AW;

  logic [FACTOR_W-1:0] factor;
  logic [GAIN_W-1:0] gain;
  logic accept;
  logic out_pop;
  cicd_push_t mid_push;
  logic mid_pop;
  logic [ACC_W-1:0] mid_data;
  logic [QUEUE_AW:0] mid_count;
  logic out_push;
  logic [SAMPLE_W-1:0] out_data;
  logic [SAMPLE_W-1:0] out_rdata;
  logic [QUEUE_AW:0] out_count;

  assign cfg_ready = 1'b1;
  assign accept = push && !full;
  assign empty = (out_count == '0);
  assign out_pop = pop && !empty;
  assign sample_out = signed'(out_rdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      factor <= FACTOR_RESET;
      gain <= GAIN_ONE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FACTOR: factor <= cfg_data[FACTOR_W-1:0];
        CFG_GAIN:   gain <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  cicd_front #(
    .STAGES(STAGES),
    .QUEUE_AW(QUEUE_AW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .sample_in(sample_in),
    .factor(factor),
    .mid_pop(mid_pop),
    .full(full),
    .mid_push(mid_push)
  );

  cicd_queue #(
    .WIDTH(ACC_W),
    .AW(QUEUE_AW)
  ) u_mid_queue (
    .clk(clk),
    .rst(rst),
    .push(mid_push.valid),
    .wdata(mid_push.data),
    .pop(mid_pop),
    .rdata(mid_data),
    .count(mid_count)
  );

  cicd_back #(
    .STAGES(STAGES),
    .QUEUE_AW(QUEUE_AW)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .mid_empty(mid_count == '0),
    .mid_data(mid_data),
    .mid_pop(mid_pop),
    .gain(gain),
    .out_pop(out_pop),
    .out_push(out_push),
    .out_data(out_data)
  );

  cicd_queue #(
    .WIDTH(SAMPLE_W),
    .AW(QUEUE_AW)
  ) u_out_queue (
    .clk(clk),
    .rst(rst),
    .push(out_push),
    .wdata(out_data),
    .pop(out_pop),
    .rdata(out_rdata),
    .count(out_count)
  );

  `ASSERT_ALWAYS(a_mid_no_overflow, clk, rst, !(mid_push.valid && mid_count == (QUEUE_AW + 1)'(QD)), "mid queue overflow")
  `ASSERT_ALWAYS(a_mid_no_underflow, clk, rst, !(mid_pop && mid_count == '0), "mid queue underflow")
  `ASSERT_ALWAYS(a_out_no_overflow, clk, rst, !(out_push && !out_pop && out_count == (QUEUE_AW + 1)'(QD)), "result queue overflow")
  `ASSERT_NEXT(a_result_arrives, clk, rst, out_push, !empty, "result request lost")

endmodule

// ----- dv/tb_cic_decimator_top.sv -----
// Self-checking testbench for the CIC decimator top level with a built-in predictor.
module tb_cic_decimator_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cicd_pkg::*;

  localparam int STAGES = STAGES_DEFAULT;
  localparam int TOTAL_ITEMS = 2000;
  localparam int SETTLE_CYCLES = 2 * STAGES + 8;
  localparam int STUCK_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam logic signed [97:0] SAT_HI = 98'sd8388607;
  localparam logic signed [97:0] SAT_LO = -98'sd8388608;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic signed [SAMPLE_W-1:0] sample_in = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [ACC_W-1:0] integ_regs [STAGES] = '{default: '0};
  logic [ACC_W-1:0] comb_regs [STAGES] = '{default: '0};
  logic [PHASE_W-1:0] phase_count = '0;
  logic [FACTOR_W-1:0] factor_reg = FACTOR_RESET;
  logic [GAIN_W-1:0] gain_reg = GAIN_ONE;

  logic signed [SAMPLE_W-1:0] expected_samples [$];
  logic signed [SAMPLE_W-1:0] want;
  logic signed [SAMPLE_W-1:0] last_sample = '0;

  int idle_pct = 9;
  int hold_cycles = 0;
  int stuck_cycles = 0;
  int fail_count = 0;
  int samples_sent = 0;
  int outputs_checked = 0;
  int reg_writes = 0;
  int input_stall_cycles = 0;

  cic_decimator_top #(.STAGES(STAGES)) dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .sample_in(sample_in),
    .empty(empty),
    .pop(pop),
    .sample_out(sample_out),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Integrates one sample and, at the end of a group, returns the scaled comb output.
  function automatic bit decimate(input logic signed [SAMPLE_W-1:0] x,
                                  output logic signed [SAMPLE_W-1:0] y);
    logic [ACC_W-1:0] acc;
    logic [ACC_W-1:0] prev;
    logic [GAIN_W-1:0] g;
    logic signed [97:0] scaled;
    int f;
    y = '0;
    f = (factor_reg == '0) ? 1 :
        (factor_reg > FACTOR_MAX) ? int'(FACTOR_MAX) : int'(factor_reg);
    g = (gain_reg > GAIN_ONE) ? GAIN_ONE : gain_reg;
    acc = {{(ACC_W - SAMPLE_W){x[SAMPLE_W-1]}}, x};
    for (int i = 0; i < STAGES; i++) begin
      integ_regs[i] += acc;
      acc = integ_regs[i];
    end
    if (int'(phase_count) + 1 < f) begin
      phase_count++;
      return 1'b0;
    end
    phase_count = '0;
    for (int i = 0; i < STAGES; i++) begin
      prev = comb_regs[i];
      comb_regs[i] = acc;
      acc -= prev;
    end
    scaled = ($signed({{34{acc[ACC_W-1]}}, acc}) * $signed({65'd0, g})) >>> 32;
    if (scaled > SAT_HI) y = 24'sh7FFFFF;
    else if (scaled < SAT_LO) y = 24'sh800000;
    else y = scaled[SAMPLE_W-1:0];
    return 1'b1;
  endfunction

  function automatic logic [GAIN_W-1:0] ideal_gain(input int f);
    return GAIN_W'(64'(GAIN_ONE) / 64'(f * f * f * f));
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] make_sample();
    int r;
    int d;
    r = $urandom_range(99);
    if (r < 35) begin
      last_sample = SAMPLE_W'($urandom());
    end else if (r < 45) begin
      case ($urandom_range(3))
        0: last_sample = 24'sh7FFFFF;
        1: last_sample = 24'sh800000;
        2: last_sample = '0;
        default: last_sample = -24'sd1;
      endcase
    end else begin
      d = int'($urandom_range(2047)) - 1024;
      last_sample = last_sample + SAMPLE_W'(d);
    end
    return last_sample;
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
    logic signed [SAMPLE_W-1:0] y;
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    sample_in <= x;
    @(posedge clk);
    while (full) @(posedge clk);
    if (decimate(x, y)) expected_samples.push_back(y);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_FACTOR) factor_reg = value[FACTOR_W-1:0];
    else if (idx == CFG_GAIN) gain_reg = value[GAIN_W-1:0];
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Samples that end no group may still be in flight, so the block gets extra cycles.
  task automatic wait_drained();
    push <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_passthrough();
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
    send_sample('0);
    send_sample(24'sd1);
    send_sample(-24'sd1);
    send_sample(24'sh555555);
    send_sample(24'shAAAAAA);
    wait_drained();
  endtask

  task automatic test_register_limits();
    write_reg(CFG_FACTOR, '0);
    write_reg(CFG_GAIN, {CFG_DATA_W{1'b1}});
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
    send_sample(24'sd12345);
    wait_drained();
    write_reg(CFG_GAIN, '0);
    send_sample(24'sh7FFFFF);
    wait_drained();
    write_reg(CFG_FACTOR, CFG_DATA_W'(2));
    write_reg(CFG_GAIN, GAIN_ONE);
    repeat (4) send_sample(24'sh7FFFFF);
    repeat (4) send_sample(24'sh800000);
    wait_drained();
  endtask

  task automatic test_factor_lowered();
    write_reg(CFG_FACTOR, CFG_DATA_W'(127));
    repeat (3) send_sample(make_sample());
    wait_drained();
    write_reg(CFG_FACTOR, CFG_DATA_W'(2));
    repeat (3) send_sample(make_sample());
    wait_drained();
  endtask

  task automatic test_backpressure();
    write_reg(CFG_FACTOR, CFG_DATA_W'(1));
    write_reg(CFG_GAIN, GAIN_ONE);
    idle_pct = 0;
    hold_cycles = HOLD_OFF_CYCLES;
    while (hold_cycles > 0) send_sample(make_sample());
    idle_pct = 9;
    wait_drained();
  endtask

  task automatic test_quiet_stretch();
    write_reg(CFG_FACTOR, CFG_DATA_W'(3));
    write_reg(CFG_GAIN, ideal_gain(3));
    idle_pct = 0;
    repeat (300) send_sample(make_sample());
    idle_pct = 9;
    wait_drained();
  endtask

  task automatic test_random_phases();
    int r;
    int f_raw;
    int f_eff;
    int n;
    logic [GAIN_W-1:0] g;
    while (samples_sent < TOTAL_ITEMS) begin
      r = $urandom_range(99);
      if (r < 55) f_raw = $urandom_range(8, 1);
      else if (r < 75) f_raw = $urandom_range(63, 9);
      else if (r < 85) f_raw = 64;
      else if (r < 92) f_raw = 0;
      else f_raw = $urandom_range(127, 65);
      f_eff = (f_raw == 0) ? 1 : (f_raw > 64) ? 64 : f_raw;
      r = $urandom_range(99);
      if (r < 45) g = ideal_gain(f_eff);
      else if (r < 55) g = GAIN_ONE;
      else if (r < 62) g = '0;
      else if (r < 72) g = {1'b1, $urandom()};
      else g = {1'($urandom()), $urandom()};
      write_reg(CFG_FACTOR, CFG_DATA_W'(f_raw));
      write_reg(CFG_GAIN, g);
      n = f_eff * $urandom_range((f_eff > 16) ? 4 : 12, 2) + $urandom_range(f_eff - 1);
      repeat (n) send_sample(make_sample());
      wait_drained();
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_cycles > 0) begin
      pop <= 1'b0;
      hold_cycles--;
    end else begin
      pop <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (expected_samples.size() == 0) begin
        $error("sample_out: expected none, got %0d", sample_out);
        fail_count++;
      end else begin
        want = expected_samples.pop_front();
        if (sample_out !== want) begin
          $error("sample_out: expected %0d, got %0d", want, sample_out);
          fail_count++;
        end
      end
      outputs_checked++;
    end
    if (!rst && push && full) input_stall_cycles++;
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_passthrough();
    test_register_limits();
    test_factor_lowered();
    test_backpressure();
    test_quiet_stretch();
    test_random_phases();
    wait_drained();
    $display("Run covered %0d samples, %0d checked outputs and %0d register writes.",
             samples_sent, outputs_checked, reg_writes);
    $display("The input was held back by a full queue for %0d cycles.", input_stall_cycles);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
